// ----- rtl/ftqm_pkg.sv -----
// Shared types, codes and defaults for the fact table query matcher.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package ftqm_pkg;

  localparam int ATOM_W         = 8;
  localparam int ARG_SLOTS      = 4;
  localparam int ARITY_W        = 3;
  localparam int CAP_W          = 6;
  localparam int SOLUTION_LIMIT = 32;

  localparam int FACT_DEPTH_DEF = 32;
  localparam int MAX_ARGS_DEF   = 4;
  localparam int ATOM_COUNT_DEF = 256;
  localparam int FUNC_DEPTH_DEF = 16;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_QUERY  = 2'd1,
    OP_MARK   = 2'd2,
    OP_CHECK  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_SOLUTION = 2'd0,
    KIND_END      = 2'd1,
    KIND_STATUS   = 2'd2,
    KIND_VERDICT  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_MALFORMED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    VD_UNKNOWN    = 2'd0,
    VD_CONFIRM    = 2'd1,
    VD_CONTRADICT = 2'd2
  } verdict_t;

  typedef struct packed {
    op_t                op;
    logic [ATOM_W-1:0]  pred_atom;
    logic [ARITY_W-1:0] arity;
    logic [ATOM_W-1:0]  arg_a;
    logic [ATOM_W-1:0]  arg_b;
    logic [ATOM_W-1:0]  arg_c;
    logic [ATOM_W-1:0]  arg_d;
    logic [3:0]         var_mask;
  } req_t;

  typedef struct packed {
    kind_t              kind;
    status_t            status;
    verdict_t           verdict;
    logic [2:0]         binding_count;
    logic [ATOM_W-1:0]  bound_first;
    logic [ATOM_W-1:0]  bound_second;
    logic [ATOM_W-1:0]  bound_third;
    logic [ATOM_W-1:0]  bound_fourth;
    logic [CAP_W-1:0]   solution_count;
    logic               last;
  } rsp_t;

  // One stored fact; unused argument slots hold zero.
  typedef struct packed {
    logic [ATOM_W-1:0]                 pred;
    logic [ARITY_W-1:0]                arity;
    logic [ARG_SLOTS-1:0][ATOM_W-1:0]  args;
  } fact_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_req;
    logic decode;
    logic fact_write;
    logic fact_scan_start;
    logic fact_scan;
    logic func_scan_start;
    logic func_scan;
    logic mark_commit;
    logic emit_final;
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    op_t  op;
    logic insert_bad;
    logic fact_full;
    logic mark_bad;
    logic fact_done;
    logic func_done;
    logic same;
    logic diff;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- rtl/fact_table_query_matcher_unit.sv -----
// Insert writes during decode; mark scans the functional set (malformed: no scan);
// query scans the fact table, pausing while a solution word waits on rsp_ready;
// check like query, plus the functional-set scan when only a differing object was
// seen. Insert, mark, check: one word; query: solutions + end. Throughput:
// sequential; one fact per cycle unless stalled; next word after the final word.
// Reset (rst, synchronous): tables empty, max_solutions = 32, no word pending.
`timescale 1ns / 1ps

module fact_table_query_matcher_unit
  import ftqm_pkg::*;
#(
  parameter int FACT_DEPTH = FACT_DEPTH_DEF,  // stored facts, 1..63
  parameter int MAX_ARGS   = MAX_ARGS_DEF,    // arguments per fact, 1..4
  parameter int ATOM_COUNT = ATOM_COUNT_DEF,  // atom ids below this are valid
  parameter int FUNC_DEPTH = FUNC_DEPTH_DEF   // functional predicates, 1..256
) (
  input  logic             clk,
  input  logic             rst,
  // request words
  input  logic             req_valid,
  output logic             req_ready,
  input  req_t             req,
  // result words
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output rsp_t             rsp,
  // max_solutions register
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data
);

  // The controller only sequences; every table, counter and the result
  // register live in the datapath. Solution words are written straight into
  // the result register during the fact scan, which pauses when a solution is due
  // while that register is full and not being taken.
  dp_cmd_t  cmd;
  dp_stat_t st;

  ftqm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .cmd       (cmd),
    .st        (st)
  );

  ftqm_dp #(
    .FACT_DEPTH (FACT_DEPTH),
    .MAX_ARGS   (MAX_ARGS),
    .ATOM_COUNT (ATOM_COUNT),
    .FUNC_DEPTH (FUNC_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

// ----- rtl/ftqm_dp.sv -----
// Datapath: request latch, fact and functional-set memories, scan pointers,
// match logic, result register and the max_solutions register. Uses ftqm_pkg.
`timescale 1ns / 1ps

module ftqm_dp
  import ftqm_pkg::*;
#(
  parameter int FACT_DEPTH = FACT_DEPTH_DEF,
  parameter int MAX_ARGS   = MAX_ARGS_DEF,
  parameter int ATOM_COUNT = ATOM_COUNT_DEF,
  parameter int FUNC_DEPTH = FUNC_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  req_t             req,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output rsp_t             rsp,
  input  dp_cmd_t          cmd,
  output dp_stat_t         st
);

  localparam int FA_W = (FACT_DEPTH > 1) ? $clog2(FACT_DEPTH) : 1;
  localparam int FC_W = $clog2(FACT_DEPTH + 1);
  localparam int UA_W = (FUNC_DEPTH > 1) ? $clog2(FUNC_DEPTH) : 1;
  localparam int UC_W = $clog2(FUNC_DEPTH + 1);

  req_t                             req_q;
  logic [CAP_W-1:0]                 max_solutions;
  logic [CAP_W-1:0]                 cap;

  fact_t                            fact_mem [FACT_DEPTH];
  fact_t                            fact_rd;
  fact_t                            new_fact;
  logic [FC_W-1:0]                  fact_count;
  logic [FC_W-1:0]                  fidx;
  logic                             fv;
  logic                             fact_full;

  logic [ATOM_W-1:0]                func_mem [FUNC_DEPTH];
  logic [ATOM_W-1:0]                func_rd;
  logic [UC_W-1:0]                  func_count;
  logic [UC_W-1:0]                  uidx;
  logic                             uv;
  logic                             func_full;
  logic                             func_issue;

  status_t                          stat;
  logic                             same;
  logic                             diff;
  logic                             found;
  logic [CAP_W-1:0]                 n;

  logic [ARG_SLOTS-1:0][ATOM_W-1:0] qargs;
  logic                             pred_bad;
  logic                             arity_bad;
  logic                             insert_bad;

  // match evaluation on the fact read out this cycle
  logic [ARG_SLOTS-1:0][ATOM_W-1:0] vars;
  logic [ARG_SLOTS-1:0][ATOM_W-1:0] bound;
  logic [2:0]                       nb;
  logic                             ok;
  logic                             hit;
  logic [ATOM_W-1:0]                hit_val;
  logic                             chk_hit;
  logic                             chk_same;

  logic                             emit_sol;
  logic                             stall;
  logic                             fact_issue;
  logic                             fact_eval;
  logic                             load_sol;
  rsp_t                             rsp_d;

  assign cfg_ready = 1'b1;
  assign qargs = {req_q.arg_d, req_q.arg_c, req_q.arg_b, req_q.arg_a};
  assign cap = (max_solutions > CAP_W'(SOLUTION_LIMIT)) ? CAP_W'(SOLUTION_LIMIT)
                                                        : max_solutions;

  assign pred_bad  = (req_q.pred_atom == '0) ||
                     (32'(req_q.pred_atom) >= 32'(ATOM_COUNT));
  assign arity_bad = (req_q.arity == '0) || (req_q.arity > ARITY_W'(MAX_ARGS));
  assign fact_full = fact_count >= FC_W'(FACT_DEPTH);
  assign func_full = func_count >= UC_W'(FUNC_DEPTH);

  always_comb begin
    insert_bad     = pred_bad || arity_bad;
    new_fact       = '0;
    new_fact.pred  = req_q.pred_atom;
    new_fact.arity = req_q.arity;
    for (int i = 0; i < ARG_SLOTS; i++) begin
      if (ARITY_W'(i) < req_q.arity) begin
        if (req_q.var_mask[i] || (32'(qargs[i]) >= 32'(ATOM_COUNT))) begin
          insert_bad = 1'b1;
        end
        new_fact.args[i] = qargs[i];
      end
    end
  end

  // Query match: constants compare, variables bind on first occurrence.
  always_comb begin
    vars    = '0;
    bound   = '0;
    nb      = '0;
    hit     = 1'b0;
    hit_val = '0;
    ok      = (fact_rd.pred == req_q.pred_atom) && (fact_rd.arity == req_q.arity);
    for (int i = 0; i < ARG_SLOTS; i++) begin
      hit     = 1'b0;
      hit_val = '0;
      if (ARITY_W'(i) < req_q.arity) begin
        if (!req_q.var_mask[i]) begin
          if (qargs[i] != fact_rd.args[i]) ok = 1'b0;
        end else begin
          for (int k = 0; k < ARG_SLOTS; k++) begin
            if ((3'(k) < nb) && (vars[k] == qargs[i])) begin
              hit     = 1'b1;
              hit_val = bound[k];
            end
          end
          if (hit) begin
            if (hit_val != fact_rd.args[i]) ok = 1'b0;
          end else begin
            vars[nb[1:0]]  = qargs[i];
            bound[nb[1:0]] = fact_rd.args[i];
            nb             = nb + 3'd1;
          end
        end
      end
    end
  end

  assign chk_hit  = (fact_rd.pred == req_q.pred_atom) && (fact_rd.arity >= ARITY_W'(2)) &&
                    (fact_rd.args[0] == qargs[0]);
  assign chk_same = chk_hit && (fact_rd.args[1] == qargs[1]);

  assign emit_sol   = (req_q.op == OP_QUERY) && ok && (n < cap);
  assign stall      = fv && emit_sol && rsp_valid && !rsp_ready;
  assign fact_issue = cmd.fact_scan && !stall && (fidx < fact_count);
  assign fact_eval  = cmd.fact_scan && fv && !stall;
  assign load_sol   = fact_eval && emit_sol;
  assign func_issue = cmd.func_scan && (uidx < func_count);

  // fact memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.fact_write) fact_mem[fact_count[FA_W-1:0]] <= new_fact;
    if (fact_issue) fact_rd <= fact_mem[fidx[FA_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.mark_commit && !found && !func_full) begin
      func_mem[func_count[UA_W-1:0]] <= req_q.pred_atom;
    end
    if (func_issue) func_rd <= func_mem[uidx[UA_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) req_q <= req;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_solutions <= CAP_W'(SOLUTION_LIMIT);
      fact_count    <= '0;
      func_count    <= '0;
      fidx          <= '0;
      fv            <= 1'b0;
      uidx          <= '0;
      uv            <= 1'b0;
      stat          <= ST_OK;
      same          <= 1'b0;
      diff          <= 1'b0;
      found         <= 1'b0;
      n             <= '0;
    end else begin
      if (cfg_valid) max_solutions <= cfg_data;
      if (cmd.fact_write) fact_count <= fact_count + FC_W'(1);

      if (cmd.decode) begin
        same  <= 1'b0;
        diff  <= 1'b0;
        found <= 1'b0;
        n     <= '0;
        if (req_q.op == OP_INSERT) begin
          stat <= insert_bad ? ST_MALFORMED : (fact_full ? ST_FULL : ST_OK);
        end else begin
          stat <= pred_bad ? ST_MALFORMED : ST_OK;
        end
      end

      if (cmd.fact_scan_start) begin
        fidx <= '0;
        fv   <= 1'b0;
      end else if (cmd.fact_scan && !stall) begin
        fv <= fact_issue;
        if (fact_issue) fidx <= fidx + FC_W'(1);
      end

      if (fact_eval && (req_q.op == OP_CHECK)) begin
        if (chk_same) same <= 1'b1;
        if (chk_hit && !chk_same) diff <= 1'b1;
      end
      if (load_sol) n <= n + CAP_W'(1);

      if (cmd.func_scan_start) begin
        uidx <= '0;
        uv   <= 1'b0;
      end else if (cmd.func_scan) begin
        uv <= func_issue;
        if (func_issue) uidx <= uidx + UC_W'(1);
      end
      if (uv && (func_rd == req_q.pred_atom)) found <= 1'b1;

      if (cmd.mark_commit) begin
        if (!found && !func_full) func_count <= func_count + UC_W'(1);
        stat <= (!found && func_full) ? ST_FULL : ST_OK;
      end
    end
  end

  // result word
  always_comb begin
    rsp_d = '0;
    if (load_sol) begin
      rsp_d.kind          = KIND_SOLUTION;
      rsp_d.binding_count = nb;
      rsp_d.bound_first   = bound[0];
      rsp_d.bound_second  = bound[1];
      rsp_d.bound_third   = bound[2];
      rsp_d.bound_fourth  = bound[3];
    end else begin
      rsp_d.last = 1'b1;
      unique case (req_q.op)
        OP_QUERY: begin
          rsp_d.kind           = KIND_END;
          rsp_d.solution_count = n;
        end
        OP_CHECK: begin
          rsp_d.kind    = KIND_VERDICT;
          rsp_d.verdict = same ? VD_CONFIRM
                               : ((diff && found) ? VD_CONTRADICT : VD_UNKNOWN);
        end
        OP_INSERT, OP_MARK: begin
          rsp_d.kind   = KIND_STATUS;
          rsp_d.status = stat;
        end
        default: rsp_d.kind = KIND_STATUS;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_sol || cmd.emit_final) rsp <= rsp_d;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_sol || cmd.emit_final) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_comb begin
    st            = '0;
    st.op         = req_q.op;
    st.insert_bad = insert_bad;
    st.fact_full  = fact_full;
    st.mark_bad   = pred_bad;
    st.fact_done  = !fv && (fidx >= fact_count);
    st.func_done  = !uv && (uidx >= func_count);
    st.same       = same;
    st.diff       = diff;
    st.out_free   = !rsp_valid || rsp_ready;
  end

`ifndef SYNTH
  a_write_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.fact_write |-> !fact_full)
    else $error("fact written into a full table");

  a_write_count: assert property (@(posedge clk) disable iff (rst)
    cmd.fact_write |=> fact_count == FC_W'($past(fact_count) + FC_W'(1)))
    else $error("fact count did not advance on write");

  a_sol_under_cap: assert property (@(posedge clk) disable iff (rst)
    load_sol |-> (n < cap) && !cmd.emit_final)
    else $error("solution emitted past cap or alongside final word");

  a_final_idle_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_final |-> !fv && !uv)
    else $error("final word issued with a scan in flight");
`endif

endmodule

// ----- rtl/ftqm_ctrl.sv -----
// Controller: one-hot sequencer that steps each request through decode, the
// fact and/or functional-set scan its op needs, and the final word. Uses ftqm_pkg.
`timescale 1ns / 1ps

module ftqm_ctrl
  import ftqm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  output dp_cmd_t  cmd,
  input  dp_stat_t st
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_QSCAN  = 5'b00100,
    S_FSCAN  = 5'b01000,
    S_RESULT = 5'b10000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        unique case (st.op)
          OP_INSERT: begin
            cmd.fact_write = !st.insert_bad && !st.fact_full;
            state_next     = S_RESULT;
          end
          OP_MARK: begin
            if (st.mark_bad) begin
              state_next = S_RESULT;
            end else begin
              cmd.func_scan_start = 1'b1;
              state_next          = S_FSCAN;
            end
          end
          OP_QUERY, OP_CHECK: begin
            cmd.fact_scan_start = 1'b1;
            state_next          = S_QSCAN;
          end
          default: state_next = S_RESULT;
        endcase
      end
      S_QSCAN: begin
        cmd.fact_scan = 1'b1;
        if (st.fact_done) begin
          // contradict needs a functional predicate, so look it up
          if ((st.op == OP_CHECK) && st.diff && !st.same) begin
            cmd.func_scan_start = 1'b1;
            state_next          = S_FSCAN;
          end else begin
            state_next = S_RESULT;
          end
        end
      end
      S_FSCAN: begin
        cmd.func_scan = 1'b1;
        if (st.func_done) begin
          cmd.mark_commit = (st.op == OP_MARK);
          state_next      = S_RESULT;
        end
      end
      S_RESULT: begin
        if (st.out_free) begin
          cmd.emit_final = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- bench/tb_fact_table_query_matcher_unit.sv -----
// Self-checking bench for fact_table_query_matcher_unit: directed and random
// request words, predicted results checked in order. Depends on ftqm_pkg.
`timescale 1ns / 1ps

module tb_fact_table_query_matcher_unit;
  import ftqm_pkg::*;

  // Mirror of the fact table, the functional set and the solution cap.
  // Every accepted request word appends the result words it must cause.
  class fact_store_mirror;
    logic [ATOM_W-1:0]                preds [FACT_DEPTH_DEF];
    logic [ARG_SLOTS-1:0][ATOM_W-1:0] fargs [FACT_DEPTH_DEF];
    int unsigned                      arities [FACT_DEPTH_DEF];
    int unsigned                      n_facts;
    logic [ATOM_W-1:0]                funcs [FUNC_DEPTH_DEF];
    int unsigned                      n_funcs;
    int unsigned                      cap;
    rsp_t                             due_words [$];
    int unsigned                      mismatches;

    function new();
      n_facts    = 0;
      n_funcs    = 0;
      cap        = SOLUTION_LIMIT;
      mismatches = 0;
    endfunction

    function void set_cap(int unsigned v);
      cap = v;
    endfunction

    function int unsigned pending();
      return due_words.size();
    endfunction

    function bit is_functional(logic [ATOM_W-1:0] p);
      for (int i = 0; i < n_funcs; i++)
        if (funcs[i] == p) return 1'b1;
      return 1'b0;
    endfunction

    function void take_request(req_t r);
      logic [ARG_SLOTS-1:0][ATOM_W-1:0] a;
      logic [ARG_SLOTS-1:0][ATOM_W-1:0] fact_args;
      logic [ATOM_W-1:0]                bound [ARG_SLOTS];
      int unsigned                      vars [ARG_SLOTS];
      int unsigned                      lim, hits, nb, k, ar;
      bit                               bad, ok, same, diff;
      rsp_t                             w;
      a  = {r.arg_d, r.arg_c, r.arg_b, r.arg_a};
      ar = r.arity;
      w  = '0;
      w.last = 1'b1;
      case (r.op)
        OP_INSERT: begin
          bad = r.pred_atom == 0 || r.pred_atom >= ATOM_COUNT_DEF ||
                ar == 0 || ar > MAX_ARGS_DEF;
          fact_args = '0;
          for (int i = 0; i < ar && !bad; i++) begin
            if (r.var_mask[i] || a[i] >= ATOM_COUNT_DEF) bad = 1'b1;
            else fact_args[i] = a[i];
          end
          w.kind = KIND_STATUS;
          // malformed wins over full
          if (bad) begin
            w.status = ST_MALFORMED;
          end else if (n_facts >= FACT_DEPTH_DEF) begin
            w.status = ST_FULL;
          end else begin
            preds[n_facts]   = r.pred_atom;
            fargs[n_facts]   = fact_args;
            arities[n_facts] = ar;
            n_facts++;
            w.status = ST_OK;
          end
          due_words.push_back(w);
        end
        OP_MARK: begin
          w.kind = KIND_STATUS;
          if (r.pred_atom == 0 || r.pred_atom >= ATOM_COUNT_DEF) begin
            w.status = ST_MALFORMED;
          end else if (is_functional(r.pred_atom)) begin
            w.status = ST_OK;  // duplicate, no change
          end else if (n_funcs >= FUNC_DEPTH_DEF) begin
            w.status = ST_FULL;
          end else begin
            funcs[n_funcs] = r.pred_atom;
            n_funcs++;
            w.status = ST_OK;
          end
          due_words.push_back(w);
        end
        OP_CHECK: begin
          same = 1'b0;
          diff = 1'b0;
          for (int f = 0; f < n_facts; f++) begin
            if (preds[f] == r.pred_atom && arities[f] >= 2 && fargs[f][0] == a[0]) begin
              if (fargs[f][1] == a[1]) same = 1'b1;
              else diff = 1'b1;
            end
          end
          w.kind = KIND_VERDICT;
          if (same) w.verdict = VD_CONFIRM;
          else if (diff && is_functional(r.pred_atom)) w.verdict = VD_CONTRADICT;
          else w.verdict = VD_UNKNOWN;
          due_words.push_back(w);
        end
        default: begin  // OP_QUERY
          lim  = (cap > SOLUTION_LIMIT) ? SOLUTION_LIMIT : cap;
          hits = 0;
          for (int f = 0; f < n_facts; f++) begin
            if (preds[f] != r.pred_atom || arities[f] != ar) continue;
            ok = 1'b1;
            nb = 0;
            for (int i = 0; i < ARG_SLOTS; i++) bound[i] = '0;
            for (int i = 0; i < ar && i < ARG_SLOTS && ok; i++) begin
              if (!r.var_mask[i]) begin
                if (a[i] != fargs[f][i]) ok = 1'b0;
              end else begin
                k = 0;
                while (k < nb && vars[k] != a[i]) k++;
                if (k < nb) begin
                  if (bound[k] != fargs[f][i]) ok = 1'b0;
                end else begin
                  vars[nb]  = a[i];
                  bound[nb] = fargs[f][i];
                  nb++;
                end
              end
            end
            // matches beyond the cap are scanned but not emitted
            if (ok && hits < lim) begin
              w = '0;
              w.kind          = KIND_SOLUTION;
              w.binding_count = 3'(nb);
              w.bound_first   = bound[0];
              w.bound_second  = bound[1];
              w.bound_third   = bound[2];
              w.bound_fourth  = bound[3];
              due_words.push_back(w);
              hits++;
            end
          end
          w = '0;
          w.kind           = KIND_END;
          w.solution_count = 6'(hits);
          w.last           = 1'b1;
          due_words.push_back(w);
        end
      endcase
    endfunction

    function void flag(string field, logic [7:0] want_v, logic [7:0] got_v);
      $display("%0t  %s: expected %0d, actual %0d", $time, field, want_v, got_v);
      mismatches++;
    endfunction

    function void match_word(rsp_t got);
      rsp_t want;
      if (due_words.size() == 0) begin
        $display("%0t  unexpected word: expected none, actual %p", $time, got);
        mismatches++;
        return;
      end
      want = due_words.pop_front();
      if (got.kind !== want.kind)                     flag("kind", want.kind, got.kind);
      if (got.status !== want.status)                 flag("status", want.status, got.status);
      if (got.verdict !== want.verdict)               flag("verdict", want.verdict, got.verdict);
      if (got.binding_count !== want.binding_count)
        flag("binding_count", want.binding_count, got.binding_count);
      if (got.bound_first !== want.bound_first)
        flag("bound_first", want.bound_first, got.bound_first);
      if (got.bound_second !== want.bound_second)
        flag("bound_second", want.bound_second, got.bound_second);
      if (got.bound_third !== want.bound_third)
        flag("bound_third", want.bound_third, got.bound_third);
      if (got.bound_fourth !== want.bound_fourth)
        flag("bound_fourth", want.bound_fourth, got.bound_fourth);
      if (got.solution_count !== want.solution_count)
        flag("solution_count", want.solution_count, got.solution_count);
      if (got.last !== want.last)                     flag("last", want.last, got.last);
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             req_valid;
  logic             req_ready;
  req_t             req;
  logic             rsp_valid;
  logic             rsp_ready;
  rsp_t             rsp;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data;

  fact_store_mirror mirror;
  int unsigned      req_calm;  // words left in a no-gap stretch, request side
  int unsigned      rsp_calm;  // same for the result side

  fact_table_query_matcher_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: the slowest legal run (33 words per request, each held off by the
  // longest draw, full-table scans) stays well under a tenth of this.
  initial begin
    #20_000_000;
    $display("%0t  timeout, %0d words outstanding", $time, mirror.pending());
    $display("[FAIL] regression broken");
    $finish;
  end

  // Per-word random idle draw, with occasional runs of back-to-back words.
  function automatic int unsigned draw_wait(inout int unsigned calm);
    if (calm != 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) calm = $urandom_range(15, 40);
    return $urandom_range(0, 5);
  endfunction

  // Small atom pool so constants and repeated variables hit stored facts.
  function automatic logic [ATOM_W-1:0] pick_atom();
    if ($urandom_range(0, 99) < 85) return ATOM_W'($urandom_range(0, 7));
    return ATOM_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [ATOM_W-1:0] pick_pred();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return '0;
    if (roll < 85) return ATOM_W'($urandom_range(1, 6));
    return ATOM_W'($urandom_range(1, 255));
  endfunction

  function automatic req_t request_of(op_t op, logic [7:0] pred, logic [2:0] arity,
                                      logic [7:0] a0, logic [7:0] a1, logic [7:0] a2,
                                      logic [7:0] a3, logic [3:0] mask);
    req_t r;
    r.op        = op;
    r.pred_atom = pred;
    r.arity     = arity;
    r.arg_a     = a0;
    r.arg_b     = a1;
    r.arg_c     = a2;
    r.arg_d     = a3;
    r.var_mask  = mask;
    return r;
  endfunction

  // Mostly well-formed words with random content; a slice of pure noise.
  function automatic req_t random_request();
    req_t                             r;
    logic [ARG_SLOTS-1:0][ATOM_W-1:0] a;
    logic [3:0]                       lo_mask;
    int unsigned                      roll;
    if ($urandom_range(0, 99) < 8) begin
      return request_of(op_t'($urandom_range(0, 3)), 8'($urandom), 3'($urandom),
                        8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                        4'($urandom));
    end
    roll = $urandom_range(0, 99);
    for (int i = 0; i < ARG_SLOTS; i++) a[i] = pick_atom();
    r = request_of(OP_QUERY, pick_pred(), 3'($urandom_range(1, 4)),
                   a[0], a[1], a[2], a[3], 4'h0);
    if (roll < 25) begin
      // insert: mask bits only above the arity, which the block ignores
      r.op      = OP_INSERT;
      lo_mask   = 4'((5'b1 << r.arity) - 5'b1);
      r.var_mask = 4'($urandom_range(0, 15)) & ~lo_mask;
    end else if (roll < 65) begin
      // query: variables numbered 0..3 so repeats are common
      r.var_mask = 4'($urandom_range(0, 15));
      for (int i = 0; i < ARG_SLOTS; i++)
        if (r.var_mask[i]) a[i] = ATOM_W'($urandom_range(0, 3));
      {r.arg_d, r.arg_c, r.arg_b, r.arg_a} = a;
    end else if (roll < 80) begin
      r.op = OP_MARK;
      if ($urandom_range(0, 99) < 40) r.pred_atom = ATOM_W'($urandom_range(1, 255));
    end else begin
      r.op       = OP_CHECK;
      r.var_mask = 4'($urandom_range(0, 15));
    end
    return r;
  endfunction

  // Called at a clock edge; returns at the edge where the word is taken.
  // valid stays high into the next call unless a gap is drawn.
  task automatic send_request(input req_t r);
    int unsigned gap;
    gap = draw_wait(req_calm);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    mirror.take_request(r);
  endtask

  // Hold the request side until every predicted word has come back.
  task automatic drain();
    req_valid <= 1'b0;
    do @(posedge clk); while (mirror.pending() != 0);
  endtask

  task automatic write_cap(input logic [CAP_W-1:0] v);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mirror.set_cap(v);
  endtask

  // Result side: random hold-offs on rsp_ready, every word checked in order.
  initial begin
    int unsigned stall;
    rsp_ready <= 1'b0;
    @(negedge rst);
    forever begin
      stall = draw_wait(rsp_calm);
      if (stall != 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!rsp_valid);
      mirror.match_word(rsp);
    end
  end

  initial begin
    logic [CAP_W-1:0] caps [6];
    mirror    = new();
    req_calm  = 0;
    rsp_calm  = 0;
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    write_cap(6'd32);

    // Directed: marks incl. invalid and duplicate predicates
    send_request(request_of(OP_MARK,   8'd0,   3'd0, 8'd0, 8'd0, 8'd0, 8'd0, 4'h0));
    send_request(request_of(OP_MARK,   8'd255, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0, 4'h0));
    send_request(request_of(OP_MARK,   8'd255, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0, 4'h0));
    send_request(request_of(OP_MARK,   8'd10,  3'd0, 8'd0, 8'd0, 8'd0, 8'd0, 4'h0));
    // malformed inserts: zero pred, zero arity, arity too big, variable in range
    send_request(request_of(OP_INSERT, 8'd0,   3'd2, 8'd1, 8'd2, 8'd0, 8'd0, 4'h0));
    send_request(request_of(OP_INSERT, 8'd10,  3'd0, 8'd1, 8'd2, 8'd0, 8'd0, 4'h0));
    send_request(request_of(OP_INSERT, 8'd10,  3'd7, 8'd1, 8'd2, 8'd3, 8'd4, 4'h0));
    send_request(request_of(OP_INSERT, 8'd10,  3'd5, 8'd1, 8'd2, 8'd3, 8'd4, 4'h0));
    send_request(request_of(OP_INSERT, 8'd10,  3'd2, 8'd1, 8'd2, 8'd0, 8'd0, 4'b0010));
    // good inserts; the first has mask bits and junk above its arity
    send_request(request_of(OP_INSERT, 8'd10,  3'd2, 8'd1, 8'd2, 8'hFF, 8'hAA, 4'b1100));
    send_request(request_of(OP_INSERT, 8'd10,  3'd2, 8'd1, 8'd3, 8'd0, 8'd0, 4'h0));
    send_request(request_of(OP_INSERT, 8'd10,  3'd1, 8'd1, 8'd0, 8'd0, 8'd0, 4'h0));
    send_request(request_of(OP_INSERT, 8'd255, 3'd4, 8'd255, 8'd255, 8'd255, 8'd255, 4'h0));
    send_request(request_of(OP_INSERT, 8'd7,   3'd3, 8'd5, 8'd5, 8'd9, 8'd0, 4'h0));
    send_request(request_of(OP_INSERT, 8'd7,   3'd3, 8'd5, 8'd6, 8'd5, 8'd0, 4'h0));
    // queries: one variable, repeated variable, all four, mask above arity
    send_request(request_of(OP_QUERY,  8'd10,  3'd2, 8'd1, 8'd0, 8'd0, 8'd0, 4'b0010));
    send_request(request_of(OP_QUERY,  8'd7,   3'd3, 8'd4, 8'd4, 8'd9, 8'd0, 4'b0011));
    send_request(request_of(OP_QUERY,  8'd255, 3'd4, 8'd0, 8'd1, 8'd2, 8'd3, 4'b1111));
    send_request(request_of(OP_QUERY,  8'd10,  3'd1, 8'd1, 8'd0, 8'd0, 8'd0, 4'b1110));
    // unmatchable queries
    send_request(request_of(OP_QUERY,  8'd0,   3'd2, 8'd1, 8'd2, 8'd0, 8'd0, 4'h0));
    send_request(request_of(OP_QUERY,  8'd10,  3'd0, 8'd1, 8'd2, 8'd0, 8'd0, 4'h0));
    send_request(request_of(OP_QUERY,  8'd10,  3'd6, 8'd1, 8'd2, 8'd0, 8'd0, 4'h0));
    // checks: confirm, contradict (functional), unknown; arity-1 fact skipped
    send_request(request_of(OP_CHECK,  8'd10,  3'd0, 8'd1, 8'd2, 8'd0, 8'd0, 4'h0));
    send_request(request_of(OP_CHECK,  8'd10,  3'd0, 8'd1, 8'd9, 8'd0, 8'd0, 4'h0));
    send_request(request_of(OP_CHECK,  8'd7,   3'd0, 8'd5, 8'd7, 8'd0, 8'd0, 4'h0));
    send_request(request_of(OP_CHECK,  8'd10,  3'd0, 8'd4, 8'd0, 8'd0, 8'd0, 4'h0));

    // Random phases, one cap setting each: extremes, truncating, default.
    caps = '{6'd3, 6'd63, 6'd1, 6'd0, 6'd32, 6'($urandom_range(1, 31))};
    foreach (caps[p]) begin
      drain();
      write_cap(caps[p]);
      repeat (72) begin
        send_request(random_request());
        if ($urandom_range(0, 39) == 0) drain();
      end
    end

    drain();
    // wait out the longest table scan; catch any stray word
    repeat (60) @(posedge clk);
    if (mirror.pending() != 0)
      $display("%0t  %0d result words never arrived", $time, mirror.pending());
    if (mirror.mismatches == 0 && mirror.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
